FILE: hdl/ue31_pkg.sv
// ue31_pkg: shared types and constants for the six-byte UTF-8 encoder.
// No dependencies; imported by the channel interfaces' users and all modules.

package ue31_pkg;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NEGATIVE  = 2'd1,
      ST_ABOVE_MAX = 2'd2,
      ST_SURROGATE = 2'd3
   } status_type;

   // One classified word in flight between front and back
   typedef struct packed {
      status_type  status;
      logic [2:0]  len;
      logic [30:0] cp;
   } job_type;

   localparam logic [30:0] MAX_CP_RESET = 31'h0010_FFFF;

   localparam logic [30:0] LIMIT_1 = 31'h0000_0080;
   localparam logic [30:0] LIMIT_2 = 31'h0000_0800;
   localparam logic [30:0] LIMIT_3 = 31'h0001_0000;
   localparam logic [30:0] LIMIT_4 = 31'h0020_0000;
   localparam logic [30:0] LIMIT_5 = 31'h0400_0000;

   localparam logic [30:0] SURR_LO = 31'h0000_D800;
   localparam logic [30:0] SURR_HI = 31'h0000_DFFF;

   localparam logic [7:0] LEAD_2    = 8'hC0;
   localparam logic [7:0] LEAD_3    = 8'hE0;
   localparam logic [7:0] LEAD_4    = 8'hF0;
   localparam logic [7:0] LEAD_5    = 8'hF8;
   localparam logic [7:0] LEAD_6    = 8'hFC;
   localparam logic [7:0] CONT_MARK = 8'h80;

endpackage

FILE: hdl/ue31_if.sv
// ue31 channel interfaces: request (code point) and response (one byte) words.
// Valid/ready handshake; no dependencies.

interface ue31_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

interface ue31_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;
   logic [1:0] status;

   modport source (output valid, output out_byte, output last_byte, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input last_byte, input status,
                   output ready);
endinterface

FILE: hdl/utf8_encoder_31bit.sv
// utf8_encoder_31bit: a request word is classified and queued in the cycle it is
// accepted; the back pops it from the queue into the output register, which holds
// its first response word. A code point of L bytes (1 to 6) gives L response words;
// an error gives one. Requests are taken every cycle while the queue has room.
// Reset (synchronous, active high) empties the queue and the output register and
// sets the maximum code point to 0x10FFFF.

module utf8_encoder_31bit import ue31_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   ue31_req_if.sink    req_ch,
   ue31_rsp_if.source  rsp_ch
);

   logic    q_push;
   job_type q_push_data;
   logic    q_full;
   logic    q_pop;
   job_type q_pop_data;
   logic    q_empty;

   ue31_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_full      (q_full)
   );

   ue31_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   ue31_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_pop      (q_pop),
      .q_pop_data (q_pop_data),
      .q_empty    (q_empty),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: hdl/ue31_front.sv
// ue31_front: holds the maximum code point register, accepts request words,
// checks and sizes them. Depends on ue31_pkg and ue31_req_if.

module ue31_front import ue31_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [30:0] csr_wr_data,
   ue31_req_if.sink   req_ch,
   output logic       q_push,
   output job_type    q_push_data,
   input  logic       q_full
);

   logic [30:0] max_cp_ff;
   logic [30:0] cp_low;
   status_type  status;
   logic [2:0]  len;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff <= MAX_CP_RESET;
      end else if (csr_wr_en) begin
         max_cp_ff <= csr_wr_data;
      end
   end

   assign cp_low = req_ch.code_point[30:0];

   // Priority: sign, then maximum, then surrogate range
   always_comb begin
      if (req_ch.code_point[31]) begin
         status = ST_NEGATIVE;
      end else if (cp_low > max_cp_ff) begin
         status = ST_ABOVE_MAX;
      end else if (cp_low >= SURR_LO && cp_low <= SURR_HI) begin
         status = ST_SURROGATE;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      if (cp_low < LIMIT_1) begin
         len = 3'd1;
      end else if (cp_low < LIMIT_2) begin
         len = 3'd2;
      end else if (cp_low < LIMIT_3) begin
         len = 3'd3;
      end else if (cp_low < LIMIT_4) begin
         len = 3'd4;
      end else if (cp_low < LIMIT_5) begin
         len = 3'd5;
      end else begin
         len = 3'd6;
      end
   end

   assign req_ch.ready       = !q_full;
   assign q_push             = req_ch.valid && !q_full;
   assign q_push_data.status = status;
   assign q_push_data.len    = len;
   assign q_push_data.cp     = cp_low;

endmodule

FILE: hdl/ue31_queue.sv
// ue31_queue: small FIFO of classified words between front and back.
// Depends on ue31_pkg.

module ue31_queue import ue31_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

FILE: hdl/ue31_back.sv
// ue31_back: pops classified words, emits the bytes via an output register,
// one response word per cycle unless stalled. Depends on ue31_pkg, ue31_rsp_if.

module ue31_back import ue31_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   output logic        q_pop,
   input  job_type     q_pop_data,
   input  logic        q_empty,
   ue31_rsp_if.source  rsp_ch
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff,      byte_in;
   logic        last_ff,      last_in;
   status_type  status_ff,    status_in;
   logic        job_valid_ff, job_valid_in;
   logic [2:0]  rem_ff,       rem_in;
   logic [29:0] cp_ff,        cp_in;
   logic        advance;
   logic [5:0]  group;
   logic [7:0]  lead;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop   = advance && !job_valid_ff && !q_empty;

   // Next continuation group, most significant first
   always_comb begin
      case (rem_ff)
         3'd1:    group = cp_ff[5:0];
         3'd2:    group = cp_ff[11:6];
         3'd3:    group = cp_ff[17:12];
         3'd4:    group = cp_ff[23:18];
         3'd5:    group = cp_ff[29:24];
         default: group = '0;
      endcase
   end

   always_comb begin
      case (q_pop_data.len)
         3'd1:    lead = {1'b0, q_pop_data.cp[6:0]};
         3'd2:    lead = LEAD_2 | {3'b000, q_pop_data.cp[10:6]};
         3'd3:    lead = LEAD_3 | {4'b0000, q_pop_data.cp[15:12]};
         3'd4:    lead = LEAD_4 | {5'b00000, q_pop_data.cp[20:18]};
         3'd5:    lead = LEAD_5 | {6'b000000, q_pop_data.cp[25:24]};
         3'd6:    lead = LEAD_6 | {7'b0000000, q_pop_data.cp[30]};
         default: lead = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      job_valid_in = job_valid_ff;
      rem_in       = rem_ff;
      cp_in        = cp_ff;
      if (advance) begin
         if (job_valid_ff) begin
            rsp_valid_in = 1'b1;
            byte_in      = CONT_MARK | {2'b00, group};
            last_in      = (rem_ff == 3'd1);
            status_in    = ST_OK;
            rem_in       = rem_ff - 1'b1;
            job_valid_in = (rem_ff != 3'd1);
         end else if (!q_empty) begin
            rsp_valid_in = 1'b1;
            if (q_pop_data.status != ST_OK) begin
               // error word: single response, no bytes
               byte_in   = '0;
               last_in   = 1'b1;
               status_in = q_pop_data.status;
            end else begin
               byte_in      = lead;
               last_in      = (q_pop_data.len == 3'd1);
               status_in    = ST_OK;
               job_valid_in = (q_pop_data.len != 3'd1);
               rem_in       = q_pop_data.len - 1'b1;
               cp_in        = q_pop_data.cp[29:0];
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         job_valid_ff <= job_valid_in;
      end
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      rem_ff    <= rem_in;
      cp_ff     <= cp_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.last_byte = last_ff;
   assign rsp_ch.status    = status_ff;

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> (last_ff && byte_ff == 8'h00))
      else $error("error response carries a byte or is not last");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (rem_ff != 3'd0 && rem_ff <= 3'd5))
      else $error("continuation count out of range");

   a_job_implies_open: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (rsp_valid_ff && !last_ff && status_ff == ST_OK))
      else $error("continuation pending after a closing response");

endmodule

FILE: dv/utf8_encoder_31bit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_encoder_31bit: random and directed code points under
// several maximum code point settings, with idle and stall bursts on both channels.
// Depends on ue31_pkg, the ue31 channel interfaces and the encoder RTL.

typedef struct {
   logic [7:0]           out_byte;
   logic                 last_byte;
   ue31_pkg::status_type status;
} utf8_word_type;

class utf8_byte_tracker;
   logic [30:0]    max_cp;
   utf8_word_type  pending_bytes[$];
   int unsigned    mismatches;
   int unsigned    points_taken;
   int unsigned    words_matched;
   int unsigned    length_seen[7];
   int unsigned    fault_seen[4];

   function new();
      max_cp = 31'h10_FFFF;
   endfunction

   function void push(input logic [7:0] b, input logic last, input ue31_pkg::status_type st);
      utf8_word_type w;
      w.out_byte  = b;
      w.last_byte = last;
      w.status    = st;
      pending_bytes.push_back(w);
   endfunction

   // Expand one accepted code point into the words it must produce
   function void take_code_point(input logic [31:0] cp);
      logic [30:0] c;
      logic [30:0] group;
      logic [7:0]  lead;
      int          n;
      c = cp[30:0];
      points_taken++;
      if (cp[31]) begin
         push(8'h00, 1'b1, ue31_pkg::ST_NEGATIVE);
         fault_seen[ue31_pkg::ST_NEGATIVE]++;
      end else if (c > max_cp) begin
         push(8'h00, 1'b1, ue31_pkg::ST_ABOVE_MAX);
         fault_seen[ue31_pkg::ST_ABOVE_MAX]++;
      end else if (c >= 31'hD800 && c <= 31'hDFFF) begin
         push(8'h00, 1'b1, ue31_pkg::ST_SURROGATE);
         fault_seen[ue31_pkg::ST_SURROGATE]++;
      end else if (c < 31'h80) begin
         push(c[7:0], 1'b1, ue31_pkg::ST_OK);
         length_seen[1]++;
      end else begin
         if (c < 31'h800) begin
            n = 2; lead = 8'hC0;
         end else if (c < 31'h1_0000) begin
            n = 3; lead = 8'hE0;
         end else if (c < 31'h20_0000) begin
            n = 4; lead = 8'hF0;
         end else if (c < 31'h400_0000) begin
            n = 5; lead = 8'hF8;
         end else begin
            n = 6; lead = 8'hFC;
         end
         length_seen[n]++;
         group = c >> (6 * (n - 1));
         push(lead | group[7:0], 1'b0, ue31_pkg::ST_OK);
         for (int k = 1; k < n; k++) begin
            group = (c >> (6 * (n - 1 - k))) & 31'h3F;
            push(8'h80 | group[7:0], k == n - 1, ue31_pkg::ST_OK);
         end
      end
   endfunction

   function void match_word(input logic [7:0] b, input logic last, input logic [1:0] st);
      utf8_word_type w;
      if (pending_bytes.size() == 0) begin
         $error("unexpected word: out_byte %h last_byte %b status %0d", b, last, st);
         mismatches++;
         return;
      end
      w = pending_bytes.pop_front();
      words_matched++;
      if (b !== w.out_byte) begin
         $error("out_byte mismatch: expected %h, actual %h", w.out_byte, b);
         mismatches++;
      end
      if (last !== w.last_byte) begin
         $error("last_byte mismatch: expected %b, actual %b", w.last_byte, last);
         mismatches++;
      end
      if (st !== w.status) begin
         $error("status mismatch: expected %0d, actual %0d", w.status, st);
         mismatches++;
      end
   endfunction
endclass

module utf8_encoder_31bit_tb;
   import ue31_pkg::*;

   localparam int unsigned RUN_LIMIT = 200_000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;

   ue31_req_if req_ch ();
   ue31_rsp_if rsp_ch ();

   utf8_byte_tracker tracker;
   bit               req_gaps_on;
   bit               rsp_stalls_on;
   int unsigned      rsp_hold_cycles;
   int unsigned      cycle_count;
   int unsigned      max_settings;

   utf8_encoder_31bit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  tracker.pending_bytes.size());
         $display("utf8_encoder_31bit test failed");
         $finish;
      end
   end

   // Response side: check every accepted word, then pick next cycle's ready
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.match_word(rsp_ch.out_byte, rsp_ch.last_byte, rsp_ch.status);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] pick_code_point(input logic [30:0] max_cp);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: r = r | 32'h8000_0000;
         1: r = 32'hD800 + $urandom_range(0, 32'h7FF);
         2: ;
         3: r = $urandom_range(0, 32'h7F);
         4: r = $urandom_range(32'h80, 32'h7FF);
         5: r = $urandom_range(32'h800, 32'hFFFF);
         6: r = $urandom_range(32'h1_0000, 32'h1F_FFFF);
         7: r = $urandom_range(32'h20_0000, 32'h3FF_FFFF);
         8: r = $urandom_range(32'h400_0000, 32'h7FFF_FFFF);
         // straddle the current maximum
         default: r = {1'b0, max_cp} + $urandom_range(0, 2) - 1;
      endcase
      return r;
   endfunction

   // Hold valid until the word is taken; maybe go idle for a burst afterwards
   task automatic offer_word(input logic [31:0] cp);
      req_ch.valid      <= 1'b1;
      req_ch.code_point <= cp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.take_code_point(cp);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.code_point <= $urandom;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic offer_random(input int unsigned count);
      repeat (count) offer_word(pick_code_point(tracker.max_cp));
   endtask

   task automatic wait_for_all_bytes();
      req_ch.valid <= 1'b0;
      while (tracker.pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Call only with the encoder drained
   task automatic write_max_code_point(input logic [30:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      tracker.max_cp  = value;
      max_settings++;
   endtask

   initial begin
      static logic [31:0] at_reset_max [15] = '{
         32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800, 32'hDFFF,
         32'hE000, 32'hFFFF, 32'h1_0000, 32'h10_FFFF, 32'h11_0000, 32'hFFFF_FFFF,
         32'h8000_0000};
      static logic [31:0] at_full_max [6] = '{
         32'h1F_FFFF, 32'h20_0000, 32'h3FF_FFFF, 32'h400_0000, 32'h7FFF_FFFF, 32'hDABC};

      tracker         = new();
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      rsp_hold_cycles = 0;
      max_settings    = 0;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.code_point <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: length boundaries, surrogate edges and fault ordering
      foreach (at_reset_max[i]) offer_word(at_reset_max[i]);
      wait_for_all_bytes();
      write_max_code_point(31'h7FFF_FFFF);
      foreach (at_full_max[i]) offer_word(at_full_max[i]);
      wait_for_all_bytes();
      write_max_code_point(31'h0);
      offer_word(32'h0);
      offer_word(32'h1);
      offer_word(32'h8000_0001);
      wait_for_all_bytes();
      // surrogates now fall above the maximum
      write_max_code_point(31'hD7FF);
      offer_word(32'hD800);
      offer_word(32'hD7FF);
      wait_for_all_bytes();

      // Random, full range; long receiver hold fills the queue and stalls the sender
      write_max_code_point(31'h7FFF_FFFF);
      offer_random(15);
      rsp_hold_cycles = 80;
      req_gaps_on     = 1'b0;
      offer_random(12);
      req_gaps_on = 1'b1;
      // sender pause until every word is back
      wait_for_all_bytes();
      offer_random(12);
      wait_for_all_bytes();

      write_max_code_point(31'($urandom_range(0, 32'h7FFF_FFFF)));
      offer_random(20);
      wait_for_all_bytes();

      // Last stretch at back-to-back rate in both directions
      write_max_code_point(31'h10_FFFF);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      offer_random(25);
      wait_for_all_bytes();

      // let any stray word show up
      repeat (20) @(posedge clock);

      $display("covered %0d code points in %0d words", tracker.points_taken,
               tracker.words_matched);
      $display("sequences of 1..6 bytes: %0d %0d %0d %0d %0d %0d",
               tracker.length_seen[1], tracker.length_seen[2], tracker.length_seen[3],
               tracker.length_seen[4], tracker.length_seen[5], tracker.length_seen[6]);
      $display("faults: %0d negative, %0d above max, %0d surrogate, over %0d max settings",
               tracker.fault_seen[ST_NEGATIVE], tracker.fault_seen[ST_ABOVE_MAX],
               tracker.fault_seen[ST_SURROGATE], max_settings);
      if (tracker.mismatches == 0 && tracker.pending_bytes.size() == 0) begin
         $display("utf8_encoder_31bit test passed");
      end else begin
         $display("utf8_encoder_31bit test failed");
      end
      $finish;
   end

endmodule
